// ----- sv/rlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// rlpm_pkg
// Types, constants and helper functions shared by the longest prefix match
// routing table.
// ----------------------------------------------------------------------------
package rlpm_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int PORT_COUNT  = 16;
   localparam int INDEX_WIDTH = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ADDR_WIDTH  = 32;
   localparam int PORT_WIDTH  = 4;
   localparam int LEN_WIDTH   = 6;
   localparam int SLOT_WIDTH  = 4;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic                  command;
      logic [SLOT_WIDTH-1:0] entry_index;
      logic                  entry_valid;
      logic [ADDR_WIDTH-1:0] route_prefix;
      logic [ADDR_WIDTH-1:0] route_netmask;
      logic [ADDR_WIDTH-1:0] route_gateway;
      logic [PORT_WIDTH-1:0] route_port;
      logic [ADDR_WIDTH-1:0] lookup_addr;
   } rlpm_req_type;

   typedef struct packed {
      logic                  found;
      logic [ADDR_WIDTH-1:0] next_hop;
      logic [PORT_WIDTH-1:0] out_port;
      logic [LEN_WIDTH-1:0]  match_length;
      logic [SLOT_WIDTH-1:0] best_index;
   } rlpm_rsp_type;

   // One stored route. The prefix length is worked out when the route is written.
   typedef struct packed {
      logic [ADDR_WIDTH-1:0] dest;
      logic [ADDR_WIDTH-1:0] mask;
      logic [ADDR_WIDTH-1:0] gateway;
      logic [PORT_WIDTH-1:0] port;
      logic [LEN_WIDTH-1:0]  plen;
   } rlpm_entry_type;

   typedef struct packed {
      logic write_en;
      logic start;
      logic read_en;
      logic load_rsp;
   } rlpm_cmd_type;

   typedef struct packed {
      logic scan_last;
   } rlpm_status_type;

   // Count of leading one bits, from bit 31 down to the first zero bit.
   function automatic logic [LEN_WIDTH-1:0] prefix_len(input logic [ADDR_WIDTH-1:0] mask);
      logic [LEN_WIDTH-1:0] len;
      len = LEN_WIDTH'(ADDR_WIDTH);
      for (int b = 0; b < ADDR_WIDTH; b++) begin
         if (!mask[b]) begin
            len = LEN_WIDTH'(ADDR_WIDTH - 1 - b);
         end
      end
      return len;
   endfunction

endpackage

// ----- sv/rlpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// rlpm_ctrl
// Controller for the routing table: takes words, sequences the table scan
// and owns the result handshake.
// ----------------------------------------------------------------------------
module rlpm_ctrl
   import rlpm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_command,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  rlpm_status_type status,
   output rlpm_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_LOAD  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.write_en = accept && (req_command == CMD_WRITE);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_LOOKUP)) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.read_en = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // The last entry read is compared during this cycle.
         ST_DRAIN: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- sv/rlpm_datapath.sv -----
// ----------------------------------------------------------------------------
// rlpm_datapath
// Route table memory, valid bits, scan counter, match compare, best-route
// tracking and the result register.
// ----------------------------------------------------------------------------
module rlpm_datapath
   import rlpm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  rlpm_req_type    req_payload,
   input  rlpm_cmd_type    cmd,
   output rlpm_status_type status,
   output rlpm_rsp_type    rsp_payload
);

   rlpm_entry_type table_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   logic [INDEX_WIDTH-1:0] addr_ff;
   logic [ADDR_WIDTH-1:0]  lookup_ff;
   rlpm_entry_type         rd_entry_ff;
   logic                   rd_valid_ff;
   logic [INDEX_WIDTH-1:0] rd_index_ff;
   logic                   cmp_en_ff;

   logic                   best_found_ff;
   logic [LEN_WIDTH-1:0]   best_len_ff;
   logic [INDEX_WIDTH-1:0] best_index_ff;
   logic [ADDR_WIDTH-1:0]  best_gateway_ff;
   logic [PORT_WIDTH-1:0]  best_port_ff;
   rlpm_rsp_type           rsp_ff;

   logic                   write_ok;
   logic [INDEX_WIDTH-1:0] wr_index;
   rlpm_entry_type         wr_entry;
   logic                   hit;
   logic                   better;

   assign wr_index = req_payload.entry_index[INDEX_WIDTH-1:0];
   assign write_ok = (32'(req_payload.entry_index) < 32'(TABLE_DEPTH))
                  && (32'(req_payload.route_port) < 32'(PORT_COUNT));

   always_comb begin
      wr_entry.dest    = req_payload.route_prefix;
      wr_entry.mask    = req_payload.route_netmask;
      wr_entry.gateway = req_payload.route_gateway;
      wr_entry.port    = req_payload.route_port;
      wr_entry.plen    = prefix_len(req_payload.route_netmask);
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en && write_ok) begin
         table_mem[wr_index] <= wr_entry;
      end
      if (cmd.read_en) begin
         rd_entry_ff <= table_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write_en && write_ok) begin
         valid_ff[wr_index] <= req_payload.entry_valid;
      end
   end

   assign status.scan_last = (addr_ff == INDEX_WIDTH'(TABLE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_en_ff <= 1'b0;
      end else begin
         cmp_en_ff <= cmd.read_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         addr_ff   <= '0;
         lookup_ff <= req_payload.lookup_addr;
      end else if (cmd.read_en) begin
         addr_ff <= addr_ff + 1'b1;
      end
      if (cmd.read_en) begin
         rd_valid_ff <= valid_ff[addr_ff];
         rd_index_ff <= addr_ff;
      end
   end

   assign hit    = cmp_en_ff && rd_valid_ff
                && ((lookup_ff & rd_entry_ff.mask) == (rd_entry_ff.dest & rd_entry_ff.mask));
   assign better = !best_found_ff || (rd_entry_ff.plen > best_len_ff);

   // Best-so-far starts at all zeros, which is also the no-match result.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_found_ff   <= 1'b0;
         best_len_ff     <= '0;
         best_index_ff   <= '0;
         best_gateway_ff <= '0;
         best_port_ff    <= '0;
      end else if (hit && better) begin
         best_found_ff   <= 1'b1;
         best_len_ff     <= rd_entry_ff.plen;
         best_index_ff   <= rd_index_ff;
         best_gateway_ff <= rd_entry_ff.gateway;
         best_port_ff    <= rd_entry_ff.port;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.found        <= best_found_ff;
         rsp_ff.next_hop     <= best_gateway_ff;
         rsp_ff.out_port     <= best_port_ff;
         rsp_ff.match_length <= best_len_ff;
         rsp_ff.best_index   <= SLOT_WIDTH'(best_index_ff);
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- sv/route_longest_prefix_match.sv -----
// ----------------------------------------------------------------------------
// route_longest_prefix_match
// IPv4 routing table with longest prefix match. A write word loads one table
// slot and gives no result. A lookup word scans the table one slot per cycle
// out of the route memory, compares the last slot read in a drain state and
// then loads its result into an output register; the next word is accepted
// only once the controller is back in idle after that load. The result sits
// in that output register, so a new word is accepted while it waits; a second
// lookup then holds in its load state until the first result is taken. A slot
// matches when (addr & mask) == (dest & mask); the longest leading-ones mask
// wins and the lowest slot wins a tie. When nothing matches, all result fields
// are zero.
// ----------------------------------------------------------------------------
module route_longest_prefix_match
   import rlpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  rlpm_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rlpm_rsp_type rsp_payload
);

   rlpm_cmd_type    cmd;
   rlpm_status_type status;

   rlpm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_payload.command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   rlpm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule
